@@ rtl/ipd_pkg.sv @@
// Shared constants for the isolated pixel detector: field widths and the
// register map of the configuration port. No dependencies.
package ipd_pkg;

  // Width of the frame size registers.
  localparam int unsigned CFG_W = 8;
  // Width of the reported row and column fields.
  localparam int unsigned POS_W = 7;

  // Configuration port sizes.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register byte addresses.
  localparam logic [APB_AW-1:0] ADDR_ROWS = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_COLS = 3'd4;

  // Frame size after reset.
  localparam logic [CFG_W-1:0] RST_DIM = 8'd128;

endpackage

@@ rtl/ipd_if.sv @@
// Stream interfaces of the isolated pixel detector: pixel input and
// result output, each with valid/ready. Depends on ipd_pkg.
interface ipd_pix_if import ipd_pkg::*;;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ipd_res_if import ipd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic             isolated;
  logic             last;
  logic             any_found;

  modport source (output valid, output row, output col, output isolated,
                  output last, output any_found, input ready);
  modport sink   (input valid, input row, input col, input isolated,
                  input last, input any_found, output ready);
endinterface

@@ rtl/isolated_pixel_detector.sv @@
// Isolated pixel detector top level: 3x3 window, line buffer memory,
// frame position counters and APB register port. Depends on ipd_pkg, ipd_if.
//
// Usage:
//   pix_i carries one binary pixel per transfer in row-major order. After
//   the frame_rows x frame_cols pixels of a frame the source sends
//   frame_cols+1 pad transfers, whose pixel bit is ignored, to flush the
//   last decisions. res_o carries one decision per pixel (row, col,
//   isolated); the first frame_cols+1 transfers of a frame give none. The
//   decision for the final pixel has last set and any_found tells whether
//   the frame held an isolated pixel.
//   Throughput is one pixel per cycle while res_o does not stall: the line
//   buffer is one memory with one read port, used at input transfer, and
//   one write port, used one stage later. A result passes the first stage
//   and the output register. The APB port holds frame_rows (0x0) and
//   frame_cols (0x4); a write restarts the frame. The user must write only
//   while the block is idle; the block does not enforce this. At reset both
//   sizes return to 128 and the frame starts over; the line buffer is not
//   cleared, rows above the first are masked by position. When res_o
//   stalls, one more pixel is taken into the stage in front of the output
//   register, and then pix_i.ready drops until res_o drains.
module isolated_pixel_detector import ipd_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ipd_pix_if.sink           pix_i,
  ipd_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Width of a clamped frame size, of the column counter and of the row
  // counter (which runs up to frame_rows+1 during the pads).
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned IC_W  = $clog2(MAX_DIM);
  localparam int unsigned RW    = $clog2(MAX_DIM + 2);
  localparam int unsigned CW    = (DIM_W > CFG_W) ? DIM_W : CFG_W;

  // Clamp a register value to the range 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end else if (ext > CW'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(ext);
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] rows_raw_q, cols_raw_q;
  logic             wr_en, wr_rows, wr_cols;
  logic [DIM_W-1:0] rows_c, cols_c;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign wr_rows = wr_en && (paddr == ADDR_ROWS);
  assign wr_cols = wr_en && (paddr == ADDR_COLS);
  assign rows_c  = clamp_dim(rows_raw_q);
  assign cols_c  = clamp_dim(cols_raw_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_raw_q <= RST_DIM;
      cols_raw_q <= RST_DIM;
    end else begin
      if (wr_rows) begin
        rows_raw_q <= pwdata[CFG_W-1:0];
      end
      if (wr_cols) begin
        cols_raw_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr)
      ADDR_ROWS: prdata = APB_DW'(rows_raw_q);
      ADDR_COLS: prdata = APB_DW'(cols_raw_q);
      default:   prdata = '0;
    endcase
  end

  // Handshake: the first stage moves on whenever the output register is
  // free or being emptied.
  logic s1_valid_q, out_valid_q;
  logic adv, in_xfer, s1_xfer;

  assign adv          = !out_valid_q || res_o.ready;
  assign pix_i.ready  = !s1_valid_q || adv;
  assign in_xfer      = pix_i.valid && pix_i.ready;
  assign s1_xfer      = s1_valid_q && adv;

  // Frame position of the incoming item and the decisions that follow
  // from it alone.
  logic [IC_W-1:0]  ic_q, ic_d;
  logic [RW-1:0]    ir_q, ir_d;
  logic [RW-1:0]    rows_p1;
  logic             pad, has_res, is_last, col_wrap;

  assign rows_p1  = RW'(rows_c) + RW'(1);
  assign pad      = ir_q >= RW'(rows_c);
  assign has_res  = (ir_q >= RW'(2)) || ((ir_q == RW'(1)) && (ic_q != '0));
  assign is_last  = (ir_q == rows_p1) && (ic_q == '0);
  assign col_wrap = DIM_W'(ic_q) == (cols_c - DIM_W'(1));

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    if (wr_rows || wr_cols) begin
      ic_d = '0;
      ir_d = '0;
    end else if (in_xfer) begin
      priority if (is_last) begin
        ic_d = '0;
        ir_d = '0;
      end else if (col_wrap) begin
        ic_d = '0;
        ir_d = ir_q + RW'(1);
      end else begin
        ic_d = ic_q + IC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
      ir_q <= '0;
    end else begin
      ic_q <= ic_d;
      ir_q <= ir_d;
    end
  end

  // First stage: the pixel with its window masks and reported position.
  typedef struct packed {
    logic             pix;
    logic [IC_W-1:0]  ic;
    logic             has_res;
    logic             last;
    logic             lmask;
    logic             tmask;
    logic             rmask;
    logic [RW-1:0]    row;
    logic [DIM_W-1:0] col;
  } s1_t;

  s1_t s1_q, s1_d;

  // With the column at 0 the center is the last pixel of two rows up and
  // the incoming column lies beyond the right edge.
  always_comb begin
    s1_d.pix     = pix_i.pixel && !pad;
    s1_d.ic      = ic_q;
    s1_d.has_res = has_res;
    s1_d.last    = is_last;
    s1_d.rmask   = (ic_q == '0);
    if (ic_q == '0) begin
      s1_d.lmask = (cols_c == DIM_W'(1));
      s1_d.tmask = (ir_q == RW'(2));
      s1_d.row   = ir_q - RW'(2);
      s1_d.col   = cols_c - DIM_W'(1);
    end else begin
      s1_d.lmask = (ic_q == IC_W'(1));
      s1_d.tmask = (ir_q == RW'(1));
      s1_d.row   = ir_q - RW'(1);
      s1_d.col   = DIM_W'(ic_q) - DIM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  // Line buffer: per column, the pixels of the two rows above the
  // incoming one ({older, newer}).
  logic [1:0] line_mem [MAX_DIM];
  logic [1:0] rd_q, eff, wr_data;
  logic       fwd_q;
  logic [1:0] fwd_data_q;

  // A one-column frame reads the entry that is written at the same edge.
  assign eff     = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {eff[0], s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q       <= line_mem[ic_q];
      fwd_data_q <= wr_data;
    end
    if (s1_xfer) begin
      line_mem[s1_q.ic] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_xfer) begin
      fwd_q <= s1_xfer && (s1_q.ic == ic_q);
    end
  end

  // 3x3 window, columns left to right, each {top, mid, bottom}.
  logic [2:0][2:0] win_q;
  logic [2:0]      new_col, col_l, col_c, col_r;
  logic            center, neigh, iso;

  assign new_col = {eff, s1_q.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_xfer) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= new_col;
    end
  end

  // Neighborhood of the reported pixel with out-of-frame parts masked.
  always_comb begin
    col_l = s1_q.lmask ? 3'b000 : win_q[1];
    col_c = win_q[2];
    col_r = s1_q.rmask ? 3'b000 : new_col;
    if (s1_q.tmask) begin
      col_l[2] = 1'b0;
      col_c[2] = 1'b0;
      col_r[2] = 1'b0;
    end
    center = col_c[1];
    neigh  = (|col_l) || (|col_r) || col_c[2] || col_c[0];
    iso    = center && !neigh;
  end

  // Frame flag for any isolated pixel.
  logic found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (wr_rows || wr_cols) begin
      found_q <= 1'b0;
    end else if (s1_xfer && s1_q.has_res) begin
      if (s1_q.last) begin
        found_q <= 1'b0;
      end else if (iso) begin
        found_q <= 1'b1;
      end
    end
  end

  // Output register.
  logic [POS_W-1:0] out_row_q, out_col_q;
  logic             out_iso_q, out_last_q, out_any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q && s1_q.has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_xfer && s1_q.has_res) begin
      out_row_q  <= POS_W'(s1_q.row);
      out_col_q  <= POS_W'(s1_q.col);
      out_iso_q  <= iso;
      out_last_q <= s1_q.last;
      out_any_q  <= s1_q.last && (found_q || iso);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.row       = out_row_q;
  assign res_o.col       = out_col_q;
  assign res_o.isolated  = out_iso_q;
  assign res_o.last      = out_last_q;
  assign res_o.any_found = out_any_q;

  // The position counters stay inside the frame plus its pads.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DIM_W'(ic_q) < cols_c)
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ir_q <= rows_p1)
    else $error("row counter beyond frame and pads");

  // An isolated final pixel must be reflected in the frame flag.
  a_last_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last && res_o.isolated) |-> res_o.any_found)
    else $error("isolated final pixel without any_found");

  // The frame flag is only reported on the final result.
  a_any_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.last) |-> !res_o.any_found)
    else $error("any_found set on a result that is not last");

  // A final result that enters the output register clears the frame flag.
  a_found_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_xfer && s1_q.has_res && s1_q.last && !wr_rows && !wr_cols) |=> !found_q)
    else $error("frame flag not cleared after final result");

endmodule

@@ tb/tb_isolated_pixel_detector.sv @@
// Self-checking testbench for the isolated pixel detector: random binary
// frames with pads, random stalls on both streams, APB frame size writes.
// Depends on ipd_pkg, ipd_if and the isolated_pixel_detector top level.
module tb_isolated_pixel_detector import ipd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM = 128;
  localparam int RING_LEN = 2 * MAX_DIM + 3;
  localparam int ITEM_GOAL = 1470;
  localparam int SETTLE_CYCLES = 8;

  // One decision as it shows on the result stream.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             isolated;
    logic             last;
    logic             any_found;
  } pix_decision_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Stream drivers, known from time zero.
  logic drv_valid = 1'b0;
  logic drv_pixel = 1'b0;
  logic sink_ready = 1'b0;

  // APB drive.
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ipd_pix_if pix_if ();
  ipd_res_if res_if ();

  assign pix_if.valid = drv_valid;
  assign pix_if.pixel = drv_pixel;
  assign res_if.ready = sink_ready;

  isolated_pixel_detector #(.MAX_DIM(MAX_DIM)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if.sink),
    .res_o  (res_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Pixels waiting to be sent, decisions waiting to come back.
  logic          pixel_feed_q[$];
  pix_decision_t decision_q[$];
  pix_decision_t seen_dec;
  pix_decision_t due_dec;

  int  fail_count = 0;
  int  items_queued = 0;
  bit  idle_on = 1'b0;
  int  src_gap = 0;
  int  sink_gap = 0;

  // Predictor state: raw size registers, pixel ring, frame position.
  logic [CFG_W-1:0] rows_reg = RST_DIM;
  logic [CFG_W-1:0] cols_reg = RST_DIM;
  bit               line_ring[RING_LEN];
  int               at_row = 0;
  int               at_col = 0;
  bit               frame_hit = 1'b0;

  // A size of zero acts as one, anything above the maximum as the maximum.
  function automatic int eff_dim(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic logic [CFG_W-1:0] big_dim();
    if ($urandom_range(0, 1) == 0) return CFG_W'(MAX_DIM);
    return CFG_W'($urandom_range(MAX_DIM + 1, 255));
  endfunction

  // Works out the decision, if any, caused by one accepted pixel transfer.
  task automatic predict_decision(input logic px);
    int rows, cols, len, total, t, final_t, p, r, c, dr, dc, nr, nc;
    bit center, neigh, iso, is_last;
    pix_decision_t dec;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    len = 2 * cols + 3;
    total = rows * cols;
    t = at_row * cols + at_col;
    final_t = total + cols;
    line_ring[t % len] = (t < total) ? px : 1'b0;

    // The pixel cols+1 positions back now has its whole neighborhood.
    if (t >= cols + 1) begin
      p = t - cols - 1;
      r = p / cols;
      c = p % cols;
      center = line_ring[p % len];
      neigh = 1'b0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = r + dr;
          nc = c + dc;
          if (!(dr == 0 && dc == 0) && nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
            if (line_ring[(nr * cols + nc) % len]) neigh = 1'b1;
          end
        end
      end
      iso = center && !neigh;
      if (iso) frame_hit = 1'b1;
      is_last = (t == final_t);
      dec.row = POS_W'(r);
      dec.col = POS_W'(c);
      dec.isolated = iso;
      dec.last = is_last;
      dec.any_found = is_last && frame_hit;
      decision_q.push_back(dec);
    end

    // Advance the frame position; the last pad ends the frame.
    if (t >= final_t) begin
      at_row = 0;
      at_col = 0;
      frame_hit = 1'b0;
    end else begin
      at_col++;
      if (at_col >= cols) begin
        at_col = 0;
        at_row++;
      end
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Pixel driver: holds an item until it is taken, idles in random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (drv_valid && pix_if.ready) predict_decision(drv_pixel);
      if (!(drv_valid && !pix_if.ready)) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          drv_valid <= 1'b0;
        end else if (pixel_feed_q.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          src_gap <= $urandom_range(0, 14);
          drv_valid <= 1'b0;
        end else begin
          drv_valid <= 1'b1;
          drv_pixel <= pixel_feed_q.pop_front();
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (res_if.valid && sink_ready) begin
        seen_dec = '{res_if.row, res_if.col, res_if.isolated, res_if.last,
                     res_if.any_found};
        if (decision_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: row %0d col %0d iso %0b last %0b any %0b",
                     seen_dec.row, seen_dec.col, seen_dec.isolated, seen_dec.last,
                     seen_dec.any_found);
        end else begin
          due_dec = decision_q.pop_front();
          if (seen_dec !== due_dec) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected row %0d col %0d iso %0b last %0b any %0b",
                       due_dec.row, due_dec.col, due_dec.isolated, due_dec.last,
                       due_dec.any_found);
              $display("                 got row %0d col %0d iso %0b last %0b any %0b",
                       seen_dec.row, seen_dec.col, seen_dec.isolated, seen_dec.last,
                       seen_dec.any_found);
            end
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        sink_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap <= $urandom_range(0, 14);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // One APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] val);
    logic [APB_DW-1:0] wd;
    wd = $urandom;
    wd[CFG_W-1:0] = val;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ROWS) rows_reg = val;
    else cols_reg = val;
    // Any write restarts the frame.
    at_row = 0;
    at_col = 0;
    frame_hit = 1'b0;
  endtask

  // Writes both sizes in random order.
  task automatic set_frame_size(input logic [CFG_W-1:0] rows_raw,
                                input logic [CFG_W-1:0] cols_raw);
    if ($urandom_range(0, 1) == 0) begin
      apb_write(ADDR_ROWS, rows_raw);
      apb_write(ADDR_COLS, cols_raw);
    end else begin
      apb_write(ADDR_COLS, cols_raw);
      apb_write(ADDR_ROWS, rows_raw);
    end
  endtask

  // Waits until every pixel is sent and every decision is back, then lets
  // the pipeline settle.
  task automatic wait_drained();
    while (pixel_feed_q.size() != 0 || drv_valid || decision_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Queues the first cut items of a frame; pads carry random ignored bits.
  task automatic queue_frame(input int rows, input int cols, input int density,
                             input int cut, input bit use_pat, input logic [63:0] pat);
    int n;
    for (n = 0; n < cut; n++) begin
      if (n >= rows * cols) pixel_feed_q.push_back(1'($urandom_range(0, 1)));
      else if (use_pat) pixel_feed_q.push_back(pat[n]);
      else pixel_feed_q.push_back($urandom_range(0, 99) < density);
    end
    items_queued += cut;
  endtask

  // Stimulus sequence and final verdict.
  initial begin : stimulus
    logic [CFG_W-1:0] rows_raw, cols_raw;
    int rows, cols, full, frames, f, cut;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 3x3 with isolated opposite corners, then single-pixel
    // frames written as size zero.
    idle_on = 1'b1;
    set_frame_size(8'd3, 8'd3);
    queue_frame(3, 3, 0, 13, 1'b1, 64'h101);
    wait_drained();
    set_frame_size(8'd0, 8'd0);
    queue_frame(1, 1, 0, 3, 1'b1, 64'h1);
    queue_frame(1, 1, 0, 3, 1'b1, 64'h0);
    wait_drained();

    // Random phases: a size setting, then whole frames, sometimes cut short.
    while (items_queued < ITEM_GOAL) begin
      idle_on = (items_queued + 300 < ITEM_GOAL) && ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 11))
        0: begin
          rows_raw = CFG_W'($urandom_range(1, 2));
          cols_raw = big_dim();
        end
        1: begin
          rows_raw = big_dim();
          cols_raw = CFG_W'($urandom_range(1, 2));
        end
        2: begin
          rows_raw = CFG_W'($urandom_range(0, 3));
          cols_raw = CFG_W'($urandom_range(0, 3));
        end
        default: begin
          rows_raw = CFG_W'($urandom_range(1, 8));
          cols_raw = CFG_W'($urandom_range(1, 12));
        end
      endcase
      set_frame_size(rows_raw, cols_raw);
      rows = eff_dim(rows_raw);
      cols = eff_dim(cols_raw);
      full = rows * cols + cols + 1;
      frames = (rows * cols > 64) ? 1 : $urandom_range(1, 4);
      for (f = 0; f < frames; f++) begin
        cut = full;
        if (f == frames - 1 && $urandom_range(0, 4) == 0) cut = $urandom_range(1, full - 1);
        queue_frame(rows, cols, $urandom_range(0, 3) * 25 + 5, cut, 1'b0, '0);
        // Now and then the sender holds off until all decisions are back.
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_isolated_pixel_detector: done, clean");
    end else begin
      $display("tb_isolated_pixel_detector: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb_isolated_pixel_detector: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ipd_pkg.sv
rtl/ipd_if.sv
rtl/isolated_pixel_detector.sv
tb/tb_isolated_pixel_detector.sv
